// ===== src/mmul4_pkg.sv =====
`timescale 1ns / 1ps

package mmul4_pkg;

  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int IDX_W             = 4;
  localparam int VAL_W             = 32;
  localparam int MAX_RESULTS       = 16;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic             first_term;
    logic             last_term;
    logic             last_elem;
    logic [IDX_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } stat_t;

endpackage

// ===== src/matrix_multiply_4x4.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   mode, element_index, element_value, start_req
// output   out        out_valid / out_ready product_index, product_value, overflow, last
//
// A start transfer launches a run of min(DIM*DIM, 16) elements, computed one at a time:
// each issues only after the previous one has finished. There is one shared multiplier
// and one read port per matrix memory, and each element sums DIM terms.
// Reset clears the control state only; matrix contents stay undefined until written.
// A stalled output holds the next element from issuing; input is taken only between runs.
module matrix_multiply_4x4 import mmul4_pkg::*; #(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic [IDX_W-1:0]        element_index,
  input  logic signed [VAL_W-1:0] element_value,
  input  logic                    start_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        product_index,
  output logic signed [VAL_W-1:0] product_value,
  output logic                    overflow,
  output logic                    last
);

  localparam int A_W = $clog2(DIM * DIM);
  localparam int K_W = $clog2(DIM);

  cmd_t           cmd;
  stat_t          stat;
  logic [A_W-1:0] left_addr;
  logic [A_W-1:0] right_addr;

  mmul4_ctrl #(
    .DIM (DIM),
    .K_W (K_W),
    .A_W (A_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_req  (start_req),
    .stat       (stat),
    .cmd        (cmd),
    .left_addr  (left_addr),
    .right_addr (right_addr)
  );

  mmul4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS),
    .A_W       (A_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .left_addr     (left_addr),
    .right_addr    (right_addr),
    .mode          (mode),
    .element_index (element_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_index (product_index),
    .product_value (product_value),
    .overflow      (overflow),
    .last          (last)
  );

endmodule

// ===== src/mmul4_ctrl.sv =====
`timescale 1ns / 1ps

module mmul4_ctrl import mmul4_pkg::*; #(
  parameter int DIM = DIM_DEFAULT,
  parameter int K_W = $clog2(DIM),
  parameter int A_W = $clog2(DIM * DIM)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           start_req,
  input  stat_t          stat,
  output cmd_t           cmd,
  output logic [A_W-1:0] left_addr,
  output logic [A_W-1:0] right_addr
);

  localparam int ELEMS = DIM * DIM;
  localparam int TOTAL = (ELEMS < MAX_RESULTS) ? ELEMS : MAX_RESULTS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]       state, state_next;
  logic [K_W-1:0]   k, k_next;
  logic [K_W-1:0]   row, row_next;
  logic [K_W-1:0]   col, col_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic             go;
  logic             last_k;
  logic             last_elem;

  assign last_k    = (k == K_W'(DIM - 1));
  assign last_elem = (pos == IDX_W'(TOTAL - 1));
  assign go        = (state == ST_ISSUE) && ((k != '0) || stat.out_free);
  assign in_ready  = (state == ST_IDLE);

  assign left_addr  = A_W'(k) * A_W'(DIM) + A_W'(row);
  assign right_addr = A_W'(col) * A_W'(DIM) + A_W'(k);

  always_comb begin
    cmd.wr_en      = in_valid && in_ready;
    cmd.rd_en      = go;
    cmd.first_term = (k == '0);
    cmd.last_term  = last_k;
    cmd.last_elem  = last_elem;
    cmd.pos        = pos;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    row_next   = row;
    col_next   = col;
    pos_next   = pos;
    case (state)
      ST_IDLE: begin
        if (in_valid && start_req) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (go) begin
          if (last_k) begin
            k_next     = '0;
            state_next = ST_WAIT;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          if (last_elem) begin
            pos_next   = '0;
            row_next   = '0;
            col_next   = '0;
            state_next = ST_IDLE;
          end else begin
            pos_next = pos + 1'b1;
            if (row == K_W'(DIM - 1)) begin
              row_next = '0;
              col_next = col + 1'b1;
            end else begin
              row_next = row + 1'b1;
            end
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      row   <= '0;
      col   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      row   <= row_next;
      col   <= col_next;
      pos   <= pos_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == ST_WAIT))
    else $error("element finished outside wait state");

  a_last_term_wait: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.last_term) |=> (state == ST_WAIT))
    else $error("final term issued without entering wait");

endmodule

// ===== src/mmul4_datapath.sv =====
`timescale 1ns / 1ps

module mmul4_datapath import mmul4_pkg::*; #(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int A_W       = $clog2(DIM * DIM)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic [A_W-1:0]          left_addr,
  input  logic [A_W-1:0]          right_addr,
  input  logic                    mode,
  input  logic [IDX_W-1:0]        element_index,
  input  logic signed [VAL_W-1:0] element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        product_index,
  output logic signed [VAL_W-1:0] product_value,
  output logic                    overflow,
  output logic                    last
);

  localparam int ELEMS  = DIM * DIM;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int TOP_W  = ACC_W - VAL_W + 1;

  logic [VAL_W-1:0]        left_mem  [ELEMS];
  logic [VAL_W-1:0]        right_mem [ELEMS];
  logic [A_W+IDX_W-1:0]    wide_idx;
  logic [A_W-1:0]          wr_addr;
  logic                    in_range;

  logic signed [VAL_W-1:0]  left_q, right_q;
  logic                     rd_v, rd_first, rd_last;
  logic signed [PROD_W-1:0] prod;
  logic                     mul_v, mul_first, mul_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;

  logic signed [ACC_W-1:0]  shifted;
  logic [TOP_W-1:0]         top_bits;
  logic                     fits;

  assign wide_idx = {{A_W{1'b0}}, element_index};
  assign wr_addr  = A_W'(wide_idx);
  assign in_range = (wide_idx < (A_W + IDX_W)'(ELEMS));

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_range && !mode) begin
      left_mem[wr_addr] <= element_value;
    end
    if (cmd.rd_en) begin
      left_q <= left_mem[left_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_range && mode) begin
      right_mem[wr_addr] <= element_value;
    end
    if (cmd.rd_en) begin
      right_q <= right_mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    rd_first  <= cmd.first_term;
    rd_last   <= cmd.last_term;
    prod      <= left_q * right_q;
    mul_first <= rd_first;
    mul_last  <= rd_last;
    if (mul_v) begin
      acc <= (mul_first ? '0 : acc) + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_v     <= cmd.rd_en;
      mul_v    <= rd_v;
      acc_done <= mul_v && mul_last;
    end
  end

  assign shifted  = acc >>> FRAC_BITS;
  assign top_bits = shifted[ACC_W-1:VAL_W-1];
  assign fits     = (&top_bits) || !(|top_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_done) begin
      product_index <= cmd.pos;
      last          <= cmd.last_elem;
      overflow      <= !fits;
      if (fits) begin
        product_value <= shifted[VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
        product_value <= {1'b1, {(VAL_W - 1){1'b0}}};
      end else begin
        product_value <= {1'b0, {(VAL_W - 1){1'b1}}};
      end
    end
  end

  assign stat.done     = acc_done;
  assign stat.out_free = !out_valid || out_ready;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> !out_valid)
    else $error("result register overwritten while full");

  a_mul_follows_read: assert property (@(posedge clk) disable iff (rst)
    mul_v |-> $past(rd_v))
    else $error("product stage without read data");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (product_value == {1'b1, {(VAL_W - 1){1'b0}}}) ||
      (product_value == {1'b0, {(VAL_W - 1){1'b1}}}))
    else $error("overflow flagged on unsaturated value");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb import mmul4_pkg::*; ();

  localparam int ELEMS      = DIM_DEFAULT * DIM_DEFAULT;
  localparam int RUN_LEN    = (ELEMS < MAX_RESULTS) ? ELEMS : MAX_RESULTS;
  localparam int LOAD_COUNT = 180;
  localparam int CALM_TAIL  = 30;

  typedef enum logic {
    LOAD_LEFT  = 1'b0,
    LOAD_RIGHT = 1'b1
  } operand_t;

  typedef struct {
    operand_t                operand;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    start;
  } load_t;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    ovf;
    logic                    last;
  } product_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    mode = LOAD_LEFT;
  logic [IDX_W-1:0]        element_index = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    start_req = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        product_index;
  logic signed [VAL_W-1:0] product_value;
  logic                    overflow;
  logic                    last;

  load_t                   pending_loads[$];
  product_t                expected_products[$];
  logic signed [VAL_W-1:0] left_m[ELEMS];
  logic signed [VAL_W-1:0] right_m[ELEMS];
  logic [ELEMS-1:0]        left_written = '0;
  logic [ELEMS-1:0]        right_written = '0;
  int unsigned             in_gap = 0;
  int unsigned             out_gap = 0;
  int unsigned             hold_left = 0;
  bit                      hold_done = 1'b0;
  int unsigned             products_seen = 0;
  int unsigned             errors = 0;
  int unsigned             loads_queued = 0;

  matrix_multiply_4x4 i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .element_index (element_index),
    .element_value (element_value),
    .start_req     (start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_index (product_index),
    .product_value (product_value),
    .overflow      (overflow),
    .last          (last)
  );

  always #5 clk = ~clk;

  function automatic void predict_products();
    logic signed [66:0] acc;
    logic signed [66:0] scaled;
    product_t           p;
    int                 c;
    int                 r;
    for (int pos = 0; pos < RUN_LEN; pos++) begin
      c   = pos / DIM_DEFAULT;
      r   = pos % DIM_DEFAULT;
      acc = '0;
      for (int k = 0; k < DIM_DEFAULT; k++) begin
        acc = acc + left_m[k*DIM_DEFAULT + r] * right_m[c*DIM_DEFAULT + k];
      end
      scaled  = acc >>> FRAC_BITS_DEFAULT;
      p.idx   = pos[IDX_W-1:0];
      p.last  = (pos == RUN_LEN - 1);
      if (scaled > 67'sd2147483647) begin
        p.value = 32'sh7FFFFFFF;
        p.ovf   = 1'b1;
      end else if (scaled < -67'sd2147483648) begin
        p.value = 32'sh80000000;
        p.ovf   = 1'b0 | 1'b1;
      end else begin
        p.value = scaled[VAL_W-1:0];
        p.ovf   = 1'b0;
      end
      expected_products.push_back(p);
    end
  endfunction

  function automatic void store_element();
    if (element_index < ELEMS) begin
      if (mode == LOAD_LEFT) left_m[element_index] = element_value;
      else right_m[element_index] = element_value;
    end
    if (start_req) predict_products();
  endfunction

  function automatic void check_product();
    product_t p;
    products_seen++;
    if (expected_products.size() == 0) begin
      $error("unexpected product element: product_index %0d product_value %h",
             product_index, product_value);
      errors++;
      return;
    end
    p = expected_products.pop_front();
    if (product_index !== p.idx) begin
      $error("product_index: expected %0d, got %0d", p.idx, product_index);
      errors++;
    end
    if (product_value !== p.value) begin
      $error("product_value: expected %h, got %h", p.value, product_value);
      errors++;
    end
    if (overflow !== p.ovf) begin
      $error("overflow: expected %0b, got %0b", p.ovf, overflow);
      errors++;
    end
    if (last !== p.last) begin
      $error("last: expected %0b, got %0b", p.last, last);
      errors++;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return '0;
      3, 4:    return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      5:       return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic queue_load(operand_t operand, int idx, logic signed [VAL_W-1:0] value,
                            bit start);
    load_t l;
    l.operand = operand;
    l.idx     = idx[IDX_W-1:0];
    l.value   = value;
    if (idx < ELEMS) begin
      if (operand == LOAD_LEFT) left_written[idx] = 1'b1;
      else right_written[idx] = 1'b1;
    end
    l.start = start && (&left_written) && (&right_written);
    pending_loads.push_back(l);
    loads_queued++;
  endtask

  // input side
  always @(posedge clk) begin
    load_t l;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) store_element();
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_loads.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        in_gap   <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_loads.size() > 0) begin
        l             = pending_loads.pop_front();
        mode          <= l.operand;
        element_index <= l.idx;
        element_value <= l.value;
        start_req     <= l.start;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_product();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && products_seen == 40) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (pending_loads.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
        out_gap   <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    for (int i = 0; i < ELEMS; i++) queue_load(LOAD_LEFT, i, 32'sh7FFFFFFF, 1'b0);
    for (int i = 0; i < ELEMS; i++) queue_load(LOAD_RIGHT, i, 32'sh7FFFFFFF, i == ELEMS - 1);
    for (int i = 0; i < DIM_DEFAULT; i++) queue_load(LOAD_RIGHT, i, 32'sh80000000, 1'b0);
    queue_load(LOAD_LEFT, 0, 32'sh80000000, 1'b1);
    queue_load(LOAD_LEFT, 5, 32'sh0000_8000, 1'b0);
    queue_load(LOAD_RIGHT, 5, -32'sd1, 1'b1);

    while (loads_queued < LOAD_COUNT) begin
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(0, 1);
        for (int i = 0; i < ELEMS; i++) begin
          queue_load(operand_t'(n), i, 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                     i == ELEMS - 1);
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          queue_load(operand_t'($urandom_range(0, 1)), $urandom_range(0, ELEMS - 1),
                     pick_value(), i == n - 1);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_loads.size() > 0 || in_valid) @(posedge clk);
    while (expected_products.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== matrix_multiply_4x4.f =====
src/mmul4_pkg.sv
src/mmul4_ctrl.sv
src/mmul4_datapath.sv
src/matrix_multiply_4x4.sv
tb/sv/tb.sv
